>>> src/windowed_periodic_trigger_macros.svh
// Assertion macros for the windowed periodic trigger.
`ifndef WINDOWED_PERIODIC_TRIGGER_MACROS_SVH
`define WINDOWED_PERIODIC_TRIGGER_MACROS_SVH

`ifndef SYNTH

// Plain property check, disabled while in reset.
`define WPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define WPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define WPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/wpt_pkg.sv
// Shared types, widths, mode tables and register indexes of the windowed periodic trigger.
package wpt_pkg;

  localparam int TICK_W     = 32;
  localparam int WIN_W      = 32;
  localparam int ZONE_W     = 17;
  localparam int MODE_W     = 5;
  localparam int MODE_COUNT = 19;
  // Dividend: window time plus zone offset magnitude, or ticks since start.
  localparam int DVD_W      = 34;
  // Divisor / remainder: largest period in cycles (two weeks at one second).
  localparam int PER_W      = 21;
  localparam int GRACE_W    = 17;
  // Signed converted window bound.
  localparam int BND_W      = 35;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CYCLE_SECONDS_DEF = 5;

  localparam logic [MODE_W-1:0] MODE_REALTIME = 5'd0;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE         = 3'd4;

  // Reset value of the window end, seconds.
  localparam logic [WIN_W-1:0] WINDOW_END_RST = 32'd3600;
  localparam logic [MODE_W-1:0] MODE_RST      = 5'd4;

  // Period of each mode in seconds; realtime has none.
  localparam logic [PER_W-1:0] PERIOD_SEC [MODE_COUNT] = '{
    21'd0,     21'd10,    21'd20,    21'd30,    21'd60,    21'd120,
    21'd300,   21'd900,   21'd1800,  21'd3600,  21'd7200,  21'd10800,
    21'd14400, 21'd21600, 21'd43200, 21'd86400, 21'd172800,
    21'd604800, 21'd1209600
  };

  // Grace count of each mode, in cycles after the period boundary.
  function automatic logic [GRACE_W-1:0] grace_cnt(input logic [MODE_W-1:0] mode);
    logic [GRACE_W-1:0] g;
    case (mode)
      5'd1:    g = 17'd1;
      5'd2:    g = 17'd1;
      5'd3:    g = 17'd2;
      5'd4:    g = 17'd4;
      5'd5:    g = 17'd8;
      5'd6:    g = 17'd20;
      5'd7:    g = 17'd60;
      5'd8:    g = 17'd120;
      5'd9:    g = 17'd240;
      5'd10:   g = 17'd480;
      5'd11:   g = 17'd720;
      5'd12:   g = 17'd960;
      5'd13:   g = 17'd1440;
      5'd14:   g = 17'd2880;
      5'd15:   g = 17'd5760;
      5'd16:   g = 17'd11520;
      5'd17:   g = 17'd86400;
      5'd18:   g = 17'd86400;
      default: g = 17'd0;
    endcase
    return g;
  endfunction

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Periodic decision request.
  typedef struct packed {
    logic              upd;
    logic [PER_W-1:0]  rem;
    logic [MODE_W-1:0] mode;
  } dec_req_t;

endpackage

>>> src/wpt_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module wpt_serdiv import wpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output div_stat_t        stat_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [PER_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  logic [PER_W-1:0] rem_q;
  logic [PER_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [PER_W:0]   trial;
  logic [PER_W:0]   trial_sub;
  logic             ge;
  logic [PER_W-1:0] rem_step;
  logic             load;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = trial >= {1'b0, dvs_q};
    rem_step  = ge ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
  end

  assign load = req_i.start && !busy_q;

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_step;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;

endmodule

>>> src/wpt_decide.sv
// Periodic fire decision with the once-per-period grace latch.
module wpt_decide import wpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dec_req_t req_i,
  output logic     fire_o
);

  logic latch_q;
  logic latch_d;
  logic in_grace;

  assign in_grace = {{(PER_W-GRACE_W){1'b0}}, grace_cnt(req_i.mode)} >= req_i.rem;

  // Boundary always fires; grace fires once; beyond grace rearms.
  always_comb begin
    latch_d = latch_q;
    fire_o  = 1'b0;
    if (req_i.rem == '0) begin
      fire_o  = 1'b1;
      latch_d = 1'b1;
    end else if (in_grace) begin
      fire_o  = !latch_q;
      latch_d = 1'b1;
    end else begin
      latch_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
    end else if (req_i.upd) begin
      latch_q <= latch_d;
    end
  end

endmodule

>>> src/windowed_periodic_trigger.sv
// Windowed periodic trigger: top level with control sequencer and config registers.
// Each tick is handled by the bit-serial divider: on the first tick after reset or after a
// window/zone write it first converts the two window bounds to cycles, then it reduces
// ticks since start modulo the period. Realtime and out-of-window ticks skip that last
// division. One tick in flight: a new tick is taken only once the last result is posted.
// Reset (async, active low): config to reset values, grace latch cleared, bounds stale.
`include "windowed_periodic_trigger_macros.svh"

module windowed_periodic_trigger import wpt_pkg::*; #(
  parameter int CYCLE_SECONDS = CYCLE_SECONDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TICK_W-1:0]     tick_count_i,
  // fire output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  fire_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LO   = 3'd1;
  localparam logic [2:0] S_HI   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Period of each mode in cycles, at least one.
  logic [PER_W-1:0] per_tab [MODE_COUNT];
  for (genvar g = 0; g < MODE_COUNT; g++) begin : g_per
    localparam int unsigned Raw = int'(PERIOD_SEC[g]) / CYCLE_SECONDS;
    assign per_tab[g] = (Raw == 0) ? PER_W'(1) : PER_W'(Raw);
  end

  // Configuration registers.
  logic              en_q;
  logic [WIN_W-1:0]  win_start_q;
  logic [WIN_W-1:0]  win_end_q;
  logic [MODE_W-1:0] mode_q;
  logic [ZONE_W-1:0] zone_q;

  // Sequencer and datapath registers.
  logic [2:0]        state_q, state_d;
  logic [TICK_W-1:0] tick_q;
  logic [BND_W-1:0]  lo_q, lo_d;
  logic [BND_W-1:0]  hi_q, hi_d;
  logic              dirty_q, dirty_d;
  logic              res_fire_q, res_fire_d;
  logic              out_valid_q, out_valid_d;
  logic              fire_q, fire_d;

  logic              in_xfer;
  logic              cfg_xfer;
  logic              out_free;
  logic              live;
  logic              periodic;
  logic [MODE_W-1:0] mode_idx;

  logic [DVD_W-1:0]  zone_ext;
  logic [DVD_W-1:0]  sum_lo, sum_hi;
  logic [DVD_W-1:0]  mag_lo, mag_hi;
  logic [BND_W-1:0]  tick_ext;
  logic [BND_W-1:0]  since_start;

  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quot;
  logic [PER_W-1:0]  div_rem;
  dec_req_t          dec_req;
  logic              dec_fire;

  // Signed bound from quotient magnitude and the sign of the dividend.
  function automatic logic [BND_W-1:0] to_bound(input logic [DVD_W-1:0] q, input logic neg);
    logic [BND_W-1:0] m;
    m = {1'b0, q};
    return neg ? (~m + 1'b1) : m;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Window times shifted by the zone offset, as sign and magnitude.
  assign zone_ext = {{(DVD_W-ZONE_W){zone_q[ZONE_W-1]}}, zone_q};
  assign sum_lo   = {{(DVD_W-WIN_W){1'b0}}, win_start_q} + zone_ext;
  assign sum_hi   = {{(DVD_W-WIN_W){1'b0}}, win_end_q} + zone_ext;
  assign mag_lo   = sum_lo[DVD_W-1] ? (~sum_lo + 1'b1) : sum_lo;
  assign mag_hi   = sum_hi[DVD_W-1] ? (~sum_hi + 1'b1) : sum_hi;

  // Window test and ticks since start.
  assign tick_ext    = {{(BND_W-TICK_W){1'b0}}, tick_q};
  assign since_start = tick_ext - lo_q;
  assign mode_idx    = (mode_q < MODE_W'(MODE_COUNT)) ? mode_q : MODE_REALTIME;
  assign periodic    = (mode_q != MODE_REALTIME);
  assign live        = en_q && ($signed(tick_ext) > $signed(lo_q))
                       && ($signed(tick_ext) < $signed(hi_q))
                       && (mode_q < MODE_W'(MODE_COUNT));

  // Divider operands follow the sequencer phase.
  always_comb begin
    div_req.start = 1'b0;
    case (state_q)
      S_IDLE: begin
        div_req.dividend = mag_lo;
        div_req.divisor  = PER_W'(CYCLE_SECONDS);
      end
      S_LO: begin
        div_req.dividend = mag_hi;
        div_req.divisor  = PER_W'(CYCLE_SECONDS);
      end
      default: begin
        div_req.dividend = since_start[DVD_W-1:0];
        div_req.divisor  = per_tab[mode_idx];
      end
    endcase

    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    dirty_d     = dirty_q;
    res_fire_d  = res_fire_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fire_d      = fire_q;
    dec_req.upd  = 1'b0;
    dec_req.rem  = div_rem;
    dec_req.mode = mode_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          div_req.start = dirty_q;
          state_d       = dirty_q ? S_LO : S_CHK;
        end
      end
      S_LO: begin
        if (div_stat.done) begin
          lo_d          = to_bound(div_quot, sum_lo[DVD_W-1]);
          div_req.start = 1'b1;
          state_d       = S_HI;
        end
      end
      S_HI: begin
        if (div_stat.done) begin
          hi_d    = to_bound(div_quot, sum_hi[DVD_W-1]);
          dirty_d = 1'b0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (live && periodic) begin
          div_req.start = 1'b1;
          state_d       = S_MOD;
        end else begin
          res_fire_d = live;
          state_d    = S_OUT;
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          dec_req.upd = 1'b1;
          res_fire_d  = dec_fire;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          fire_d      = res_fire_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Window or zone writes make the converted bounds stale.
    if (cfg_xfer && (cfg_index_i == REG_WINDOW_START || cfg_index_i == REG_WINDOW_END
                     || cfg_index_i == REG_ZONE)) begin
      dirty_d = 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      win_start_q <= '0;
      win_end_q   <= WINDOW_END_RST;
      mode_q      <= MODE_RST;
      zone_q      <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        REG_ENABLE:       en_q        <= cfg_data_i[0];
        REG_WINDOW_START: win_start_q <= cfg_data_i[WIN_W-1:0];
        REG_WINDOW_END:   win_end_q   <= cfg_data_i[WIN_W-1:0];
        REG_MODE:         mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_ZONE:         zone_q      <= cfg_data_i[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q <= tick_count_i;
    end
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    res_fire_q <= res_fire_d;
    fire_q     <= fire_d;
  end

  wpt_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  wpt_decide u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dec_req),
    .fire_o (dec_fire)
  );

  assign out_valid_o = out_valid_q;
  assign fire_o      = fire_q;

  // Checks.
  `WPT_ASSERT_NEXT(a_one_tick_in_flight, clk_i, rst_ni, in_xfer, !in_ready_o, "second tick taken while busy")
  `WPT_ASSERT(a_div_done_in_phase, clk_i, rst_ni, div_stat.done |-> (state_q == S_LO || state_q == S_HI || state_q == S_MOD), "divider finished outside a divide phase")
  `WPT_ASSERT(a_div_idle_when_ready, clk_i, rst_ni, (state_q == S_IDLE) |-> !div_stat.busy, "divider busy while idle")
  `WPT_ASSERT_NEXT(a_result_posted, clk_i, rst_ni, (state_q == S_OUT) && out_free, out_valid_o && in_ready_o, "result not posted")

endmodule

>>> tb/windowed_periodic_trigger_tb.sv
// Self-checking testbench of the windowed periodic trigger: tick transfers in, fire flags checked.
module windowed_periodic_trigger_tb import wpt_pkg::*;;

  localparam int CYC_SEC      = 5;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_GAP      = 10;
  localparam int PHASES       = 20;
  localparam int PHASE_ITEMS  = 90;
  localparam int ZONE_MAX     = 50400;
  localparam longint TICK_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_TOP     = 5'd31;

  // Period in seconds and grace in cycles, per interval mode
  longint period_sec_tab [MODE_COUNT] = '{
    0, 10, 20, 30, 60, 120, 300, 900, 1800, 3600, 7200,
    10800, 14400, 21600, 43200, 86400, 172800, 604800, 1209600
  };
  longint grace_tab [MODE_COUNT] = '{
    0, 1, 1, 2, 4, 8, 20, 60, 120, 240, 480,
    720, 960, 1440, 2880, 5760, 11520, 86400, 86400
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [TICK_W-1:0]     tick_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  fire_o;

  // Shadow of the trigger configuration and grace latch
  bit                       cur_enable = 1'b0;
  logic [WIN_W-1:0]         cur_start  = '0;
  logic [WIN_W-1:0]         cur_end    = WINDOW_END_RST;
  logic [MODE_W-1:0]        cur_mode   = MODE_RST;
  logic signed [ZONE_W-1:0] cur_zone   = '0;
  bit                       grace_latch = 1'b0;

  bit expected_fire [$];
  bit fire_want;
  int mismatches = 0;
  int ready_hold = 0;
  bit steady     = 1'b0;

  windowed_periodic_trigger #(
    .CYCLE_SECONDS (CYC_SEC)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_count_i (tick_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fire_o       (fire_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Window time in seconds plus zone, converted to cycles, truncated toward zero
  function automatic longint to_cycles(input logic [WIN_W-1:0] sec,
                                       input logic signed [ZONE_W-1:0] zone);
    longint total;
    total = sec;
    total = total + zone;
    return total / CYC_SEC;
  endfunction

  function automatic longint period_cycles(input logic [MODE_W-1:0] mode);
    longint per;
    per = (mode < MODE_COUNT) ? period_sec_tab[mode] / CYC_SEC : 0;
    return (per == 0) ? 1 : per;
  endfunction

  function automatic longint grace_of(input logic [MODE_W-1:0] mode);
    return (mode < MODE_COUNT) ? grace_tab[mode] : 0;
  endfunction

  // Expected fire flag for one tick; advances the grace latch
  function automatic bit trigger_fires(input logic [TICK_W-1:0] tick);
    longint t, lo, hi, rem;
    bit fire;
    t    = tick;
    lo   = to_cycles(cur_start, cur_zone);
    hi   = to_cycles(cur_end, cur_zone);
    fire = 1'b0;
    if (cur_enable && t > lo && t < hi && cur_mode < MODE_COUNT) begin
      if (cur_mode == MODE_REALTIME) begin
        fire = 1'b1;
      end else begin
        rem = (t - lo) % period_cycles(cur_mode);
        if (rem == 0) begin
          grace_latch = 1'b1;
          fire        = 1'b1;
        end else if (rem <= grace_tab[cur_mode]) begin
          if (!grace_latch) begin
            grace_latch = 1'b1;
            fire        = 1'b1;
          end
        end else begin
          grace_latch = 1'b0;
        end
      end
    end
    return fire;
  endfunction

  // One tick transfer; entered and left at a falling edge
  task automatic send_tick(input logic [TICK_W-1:0] tick);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tick_count_i <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    expected_fire.push_back(trigger_fires(tick));
    @(negedge clk_i);
  endtask

  // Register write, only once every pending fire flag has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (expected_fire.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ENABLE:       cur_enable = data[0];
      REG_WINDOW_START: cur_start  = data;
      REG_WINDOW_END:   cur_end    = data;
      REG_MODE:         cur_mode   = data[MODE_W-1:0];
      REG_ZONE:         cur_zone   = data[ZONE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(input bit en, input logic [WIN_W-1:0] start_s,
                            input logic [WIN_W-1:0] end_s, input logic [MODE_W-1:0] mode,
                            input int zone);
    write_reg(REG_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_WINDOW_START, start_s);
    write_reg(REG_WINDOW_END, end_s);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_ZONE, zone);
  endtask

  // Reset values: disabled first, then enabled with the default 60 s mode and one-hour window
  task automatic test_after_reset();
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd5);
    write_reg(REG_ENABLE, 32'd1);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd5);
    send_tick(32'd6);
    send_tick(32'd12);
    send_tick(32'd13);
    send_tick(32'd719);
    send_tick(32'd720);
  endtask

  // Grace latch holds across a disabled stretch
  task automatic test_latch_hold();
    send_tick(32'd12);
    write_reg(REG_ENABLE, 32'd0);
    send_tick(32'd13);
    write_reg(REG_ENABLE, 32'd1);
    send_tick(32'd14);
  endtask

  // Negative start bound truncates toward zero, not down
  task automatic test_bound_rounding();
    set_window(1'b1, 32'd0, 32'd3600, MODE_REALTIME, -7);
    send_tick(32'd0);
    write_reg(REG_ZONE, 32'd3);
    send_tick(32'd0);
  endtask

  // Extreme window times and zone offsets
  task automatic test_bound_extremes();
    set_window(1'b1, 32'd0, 32'd0, MODE_REALTIME, -ZONE_MAX);
    send_tick(32'd0);
    set_window(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_REALTIME, ZONE_MAX);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd859003539);
    write_reg(REG_WINDOW_START, 32'd0);
    send_tick(32'd859003538);
  endtask

  // Undefined mode, longest period, and writes to unused indexes
  task automatic test_mode_codes();
    set_window(1'b1, 32'd0, 32'hFFFF_FFFF, MODE_TOP, 0);
    send_tick(32'd1);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_COUNT - 1));
    send_tick(32'd241920);
    send_tick(32'd241921);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_tick(32'd241922);
  endtask

  // One random configuration followed by tick sequences walking period boundaries
  task automatic run_phase(input logic [MODE_W-1:0] mode, input int n_items);
    logic [WIN_W-1:0] start_s, end_s;
    longint end_full, span, lo, hi, per, grace, t, k, step;
    int zone;
    zone = int'($urandom_range(0, 2 * ZONE_MAX)) - ZONE_MAX;
    case ($urandom_range(0, 3))
      0:       start_s = $urandom;
      1:       start_s = $urandom_range(0, 1000);
      default: start_s = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    if (mode > MODE_REALTIME && mode < MODE_COUNT)
      span = period_sec_tab[mode] * longint'($urandom_range(2, 40));
    else
      span = $urandom_range(1, 200000);
    end_full = longint'(start_s) + span + longint'($urandom_range(0, 99));
    end_s    = (end_full > TICK_MAX) ? 32'hFFFF_FFFF : end_full[31:0];
    if ($urandom_range(0, 5) == 0) end_s = $urandom;
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    set_window($urandom_range(0, 9) != 0, start_s, end_s, mode, zone);

    lo    = to_cycles(cur_start, cur_zone);
    hi    = to_cycles(cur_end, cur_zone);
    per   = period_cycles(mode);
    grace = grace_of(mode);
    t     = -1;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: anywhere, or hugging a window edge
        case ($urandom_range(0, 2))
          0:       t = $urandom;
          1:       t = lo + longint'($urandom_range(0, 4)) - 2;
          default: t = hi + longint'($urandom_range(0, 4)) - 2;
        endcase
        if (t < 0) t = 0;
        if (t > TICK_MAX) t = TICK_MAX;
        send_tick(t[31:0]);
        t = -1;
      end else begin
        if (t < 0 || t >= TICK_MAX || $urandom_range(0, 29) == 0) begin
          // start a sequence just before a period boundary
          k = (hi > lo) ? (hi - lo) / per : 0;
          k = $urandom_range(0, k[31:0]);
          t = lo + per * k - longint'($urandom_range(0, 2));
          if (t < 0) t = 0;
        end else begin
          case ($urandom_range(0, 9))
            7, 8:    step = 1 + longint'($urandom_range(0, (grace / 3)));
            9:       step = 1 + longint'($urandom_range(0, per));
            default: step = 1;
          endcase
          t = t + step;
        end
        if (t > TICK_MAX) t = TICK_MAX;
        send_tick(t[31:0]);
      end
    end
  endtask

  // Every mode in turn, then an undefined one; every fourth phase runs without idling
  task automatic test_random_phases();
    logic [MODE_W-1:0] mode;
    for (int p = 0; p < PHASES; p++) begin
      steady = (p % 4 == 3);
      mode   = (p < MODE_COUNT) ? MODE_W'(p) : MODE_W'($urandom_range(MODE_COUNT, MODE_TOP));
      run_phase(mode, PHASE_ITEMS);
    end
    steady = 1'b0;
  endtask

  // Fire flag check at the rising edge, then draw the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fire.size() == 0) begin
        $display("%0t: fire transfer with none expected, expected none, actual %0b",
                 $time, fire_o);
        mismatches++;
      end else begin
        fire_want = expected_fire.pop_front();
        if (fire_o !== fire_want) begin
          $display("%0t: fire mismatch, expected %0b, actual %0b", $time, fire_want, fire_o);
          mismatches++;
        end
      end
      ready_hold = steady ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_latch_hold();
    test_bound_rounding();
    test_bound_extremes();
    test_mode_codes();
    test_random_phases();
    in_valid_i <= 1'b0;
    while (expected_fire.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
